### design/rd_pkg.sv
package rd_pkg;

    localparam int COORD_BITS = 16;
    localparam int NUM_PIECES = 4;

    localparam logic [1:0] ST_NO_OVERLAP = 2'd0;
    localparam logic [1:0] ST_COVERED    = 2'd1;
    localparam logic [1:0] ST_PIECE      = 2'd2;

    localparam logic [1:0] KIND_LEFT   = 2'd0;
    localparam logic [1:0] KIND_RIGHT  = 2'd1;
    localparam logic [1:0] KIND_TOP    = 2'd2;
    localparam logic [1:0] KIND_BOTTOM = 2'd3;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic [COORD_BITS-1:0]        t_size;

    typedef struct packed {
        t_coord a_left;
        t_coord a_top;
        t_coord a_right;
        t_coord a_bottom;
        t_coord b_left;
        t_coord b_top;
        t_coord b_right;
        t_coord b_bottom;
    } t_rd_in;

    typedef struct packed {
        logic [1:0] status;
        t_coord     piece_left;
        t_coord     piece_top;
        t_size      piece_width;
        t_size      piece_height;
        logic [1:0] piece_kind;
        logic       last;
    } t_rd_out;

    typedef struct packed {
        t_coord x1;
        t_coord x2;
        t_coord y1;
        t_coord y2;
    } t_rd_box;

    typedef struct packed {
        t_rd_box a;
        t_rd_box b;
    } t_rd_pair;

    typedef struct packed {
        logic empty;
        logic lft;
        logic rgt;
        logic top;
        logic bot;
    } t_rd_flags;

    typedef struct packed {
        t_rd_pair  pair;
        t_coord    cx1;
        t_coord    cx2;
        t_rd_flags flags;
    } t_rd_clip;

    typedef t_rd_out [NUM_PIECES-1:0] t_rd_list;

    typedef struct packed {
        t_rd_list          list;
        logic [NUM_PIECES-1:0] mask;
    } t_rd_slice;

endpackage

### design/rd_sort.sv
module rd_sort (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  rd_pkg::t_rd_in i_beat,
    output logic          o_valid,
    input  logic          i_stall,
    output rd_pkg::t_rd_pair o_pair
);

    logic             r_valid;
    rd_pkg::t_rd_pair r_pair;
    rd_pkg::t_rd_pair n_pair;

    assign o_stall = r_valid && i_stall;

    // order each axis as min..max
    always_comb begin
        n_pair.a.x1 = (i_beat.a_left <= i_beat.a_right) ? i_beat.a_left : i_beat.a_right;
        n_pair.a.x2 = (i_beat.a_left <= i_beat.a_right) ? i_beat.a_right : i_beat.a_left;
        n_pair.a.y1 = (i_beat.a_top <= i_beat.a_bottom) ? i_beat.a_top : i_beat.a_bottom;
        n_pair.a.y2 = (i_beat.a_top <= i_beat.a_bottom) ? i_beat.a_bottom : i_beat.a_top;
        n_pair.b.x1 = (i_beat.b_left <= i_beat.b_right) ? i_beat.b_left : i_beat.b_right;
        n_pair.b.x2 = (i_beat.b_left <= i_beat.b_right) ? i_beat.b_right : i_beat.b_left;
        n_pair.b.y1 = (i_beat.b_top <= i_beat.b_bottom) ? i_beat.b_top : i_beat.b_bottom;
        n_pair.b.y2 = (i_beat.b_top <= i_beat.b_bottom) ? i_beat.b_bottom : i_beat.b_top;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall) begin
            r_pair <= n_pair;
        end
    end

    assign o_valid = r_valid;
    assign o_pair  = r_pair;

endmodule

### design/rd_clip.sv
module rd_clip (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  rd_pkg::t_rd_pair i_pair,
    output logic             o_valid,
    input  logic             i_stall,
    output rd_pkg::t_rd_clip o_clip
);

    logic             r_valid;
    rd_pkg::t_rd_clip r_clip;
    rd_pkg::t_rd_clip n_clip;

    assign o_stall = r_valid && i_stall;

    always_comb begin
        n_clip.pair = i_pair;
        n_clip.cx1  = (i_pair.a.x1 > i_pair.b.x1) ? i_pair.a.x1 : i_pair.b.x1;
        n_clip.cx2  = (i_pair.a.x2 < i_pair.b.x2) ? i_pair.a.x2 : i_pair.b.x2;
        n_clip.flags.empty = (i_pair.a.x2 <= i_pair.b.x1) || (i_pair.b.x2 <= i_pair.a.x1) ||
                             (i_pair.a.y2 <= i_pair.b.y1) || (i_pair.b.y2 <= i_pair.a.y1) ||
                             (i_pair.a.x1 == i_pair.a.x2) || (i_pair.a.y1 == i_pair.a.y2) ||
                             (i_pair.b.x1 == i_pair.b.x2) || (i_pair.b.y1 == i_pair.b.y2);
        n_clip.flags.lft = i_pair.a.x1 < i_pair.b.x1;
        n_clip.flags.rgt = i_pair.a.x2 > i_pair.b.x2;
        n_clip.flags.top = i_pair.a.y1 < i_pair.b.y1;
        n_clip.flags.bot = i_pair.a.y2 > i_pair.b.y2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall) begin
            r_clip <= n_clip;
        end
    end

    assign o_valid = r_valid;
    assign o_clip  = r_clip;

endmodule

### design/rd_slice.sv
module rd_slice (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  rd_pkg::t_rd_clip  i_clip,
    output logic              o_valid,
    input  logic              i_stall,
    output rd_pkg::t_rd_slice o_slice
);

    logic              r_valid;
    rd_pkg::t_rd_slice r_slice;
    rd_pkg::t_rd_slice n_slice;
    rd_pkg::t_rd_box   a;
    rd_pkg::t_rd_box   b;
    rd_pkg::t_size     full_h;
    rd_pkg::t_size     mid_w;
    rd_pkg::t_rd_out   blank;

    assign o_stall = r_valid && i_stall;
    assign a       = i_clip.pair.a;
    assign b       = i_clip.pair.b;
    assign full_h  = rd_pkg::t_size'(a.y2 - a.y1);
    assign mid_w   = rd_pkg::t_size'(i_clip.cx2 - i_clip.cx1);

    always_comb begin
        blank = '0;

        n_slice.list[0] = '{status: rd_pkg::ST_PIECE, piece_left: a.x1, piece_top: a.y1,
                            piece_width: rd_pkg::t_size'(b.x1 - a.x1), piece_height: full_h,
                            piece_kind: rd_pkg::KIND_LEFT, last: 1'b0};
        n_slice.list[1] = '{status: rd_pkg::ST_PIECE, piece_left: b.x2, piece_top: a.y1,
                            piece_width: rd_pkg::t_size'(a.x2 - b.x2), piece_height: full_h,
                            piece_kind: rd_pkg::KIND_RIGHT, last: 1'b0};
        n_slice.list[2] = '{status: rd_pkg::ST_PIECE, piece_left: i_clip.cx1, piece_top: a.y1,
                            piece_width: mid_w, piece_height: rd_pkg::t_size'(b.y1 - a.y1),
                            piece_kind: rd_pkg::KIND_TOP, last: 1'b0};
        n_slice.list[3] = '{status: rd_pkg::ST_PIECE, piece_left: i_clip.cx1, piece_top: b.y2,
                            piece_width: mid_w, piece_height: rd_pkg::t_size'(a.y2 - b.y2),
                            piece_kind: rd_pkg::KIND_BOTTOM, last: 1'b0};
        n_slice.mask = {i_clip.flags.bot, i_clip.flags.top, i_clip.flags.rgt, i_clip.flags.lft};

        if (i_clip.flags.empty) begin
            n_slice.list[0]        = blank;
            n_slice.list[0].status = rd_pkg::ST_NO_OVERLAP;
            n_slice.mask           = 4'b0001;
        end else if (n_slice.mask == '0) begin
            n_slice.list[0]        = blank;
            n_slice.list[0].status = rd_pkg::ST_COVERED;
            n_slice.mask           = 4'b0001;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall) begin
            r_slice <= n_slice;
        end
    end

    assign o_valid = r_valid;
    assign o_slice = r_slice;

endmodule

### design/rd_emit.sv
module rd_emit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  rd_pkg::t_rd_slice i_slice,
    output logic              o_valid,
    input  logic              i_stall,
    output rd_pkg::t_rd_out   o_beat
);

    logic [rd_pkg::NUM_PIECES-1:0] r_pend;
    rd_pkg::t_rd_list              r_list;
    logic                          r_out_valid;
    rd_pkg::t_rd_out               r_out;
    rd_pkg::t_rd_out               n_out;
    logic [rd_pkg::NUM_PIECES-1:0] sel_oh;
    logic [rd_pkg::NUM_PIECES-1:0] rem;
    logic [1:0]                    sel_idx;
    logic                          out_ld;
    logic                          take;

    assign out_ld = !r_out_valid || !i_stall;
    assign sel_oh = r_pend & (~r_pend + 4'd1);
    assign rem    = r_pend & ~sel_oh;
    assign take   = (r_pend == '0) || (out_ld && (rem == '0));
    assign o_stall = !take;

    always_comb begin
        case (sel_oh)
            4'b0010: sel_idx = 2'd1;
            4'b0100: sel_idx = 2'd2;
            4'b1000: sel_idx = 2'd3;
            default: sel_idx = 2'd0;
        endcase
        n_out      = r_list[sel_idx];
        n_out.last = (rem == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_ld) begin
                r_out_valid <= (r_pend != '0);
            end
            if (take && i_valid) begin
                r_pend <= i_slice.mask;
            end else if (out_ld) begin
                r_pend <= rem;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && i_valid) begin
            r_list <= i_slice.list;
        end
        if (out_ld && (r_pend != '0)) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_beat  = r_out;

endmodule

### design/rectangle_difference.sv
// channel | direction | valid        | stall        | beat
// in      | input     | i_in_valid   | o_in_stall   | i_in_beat  (rd_pkg::t_rd_in)
// out     | output    | o_out_valid  | i_out_stall  | o_out_beat (rd_pkg::t_rd_out)
//
// Path: sort, clip and slice registers, then emit's list and output registers.
// Throughput: one result beat per cycle while i_out_stall is low; an item gives
// one to four results, sent one at a time from the emit stage's single output register.
// Reset: i_rst_n synchronous, active low; clears all stage valid bits.
// Stalls: i_out_stall holds the output beat and backs up through every stage.
module rectangle_difference (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  rd_pkg::t_rd_in  i_in_beat,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output rd_pkg::t_rd_out o_out_beat
);

    logic              s1_valid;
    logic              s1_stall;
    rd_pkg::t_rd_pair  s1_pair;
    logic              s2_valid;
    logic              s2_stall;
    rd_pkg::t_rd_clip  s2_clip;
    logic              s3_valid;
    logic              s3_stall;
    rd_pkg::t_rd_slice s3_slice;

    rd_sort u_sort (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_beat  (i_in_beat),
        .o_valid (s1_valid),
        .i_stall (s1_stall),
        .o_pair  (s1_pair)
    );

    rd_clip u_clip (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s1_valid),
        .o_stall (s1_stall),
        .i_pair  (s1_pair),
        .o_valid (s2_valid),
        .i_stall (s2_stall),
        .o_clip  (s2_clip)
    );

    rd_slice u_slice (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s2_valid),
        .o_stall (s2_stall),
        .i_clip  (s2_clip),
        .o_valid (s3_valid),
        .i_stall (s3_stall),
        .o_slice (s3_slice)
    );

    rd_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s3_valid),
        .o_stall (s3_stall),
        .i_slice (s3_slice),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_beat  (o_out_beat)
    );

    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_beat.status != rd_pkg::ST_PIECE) |-> o_out_beat.last)
        else $error("non-piece result not marked last");

    a_piece_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_beat.status == rd_pkg::ST_PIECE) |->
        (o_out_beat.piece_width != '0) && (o_out_beat.piece_height != '0))
        else $error("empty piece emitted");

    a_blank_geom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_beat.status != rd_pkg::ST_PIECE) |->
        (o_out_beat.piece_left == '0) && (o_out_beat.piece_top == '0) &&
        (o_out_beat.piece_width == '0) && (o_out_beat.piece_height == '0) &&
        (o_out_beat.piece_kind == rd_pkg::KIND_LEFT))
        else $error("non-piece result carries geometry");

endmodule

### test/tb_rectangle_difference.sv
`timescale 1ns / 100ps

module tb_rectangle_difference;

    localparam int CORNER_VALS[8] = '{-32768, -32767, -1, 0, 1, 2, 32766, 32767};

    class rect_scoreboard;
        rd_pkg::t_rd_out expected_q[$];
        int errors;
        int pairs;
        int beats;
        int no_overlap_cnt;
        int covered_cnt;
        int piece_cnt;

        task flag_mismatch(string msg);
            errors++;
            if (errors <= 50) begin
                $display("[%0t] mismatch: %s", $time, msg);
            end
        endtask

        function int lo_of(rd_pkg::t_coord u, rd_pkg::t_coord v);
            return (u < v) ? int'(u) : int'(v);
        endfunction

        function int hi_of(rd_pkg::t_coord u, rd_pkg::t_coord v);
            return (u > v) ? int'(u) : int'(v);
        endfunction

        function rd_pkg::t_rd_out make_piece(logic [1:0] kind, int x, int y, int w, int h);
            rd_pkg::t_rd_out r;
            r = '0;
            r.status       = rd_pkg::ST_PIECE;
            r.piece_left   = rd_pkg::t_coord'(x);
            r.piece_top    = rd_pkg::t_coord'(y);
            r.piece_width  = rd_pkg::t_size'(w);
            r.piece_height = rd_pkg::t_size'(h);
            r.piece_kind   = kind;
            return r;
        endfunction

        function void note_pair(rd_pkg::t_rd_in p);
            int ax1, ax2, ay1, ay2, bx1, bx2, by1, by2, cx1, cx2;
            rd_pkg::t_rd_out batch[$];
            rd_pkg::t_rd_out r;
            ax1 = lo_of(p.a_left, p.a_right);
            ax2 = hi_of(p.a_left, p.a_right);
            ay1 = lo_of(p.a_top, p.a_bottom);
            ay2 = hi_of(p.a_top, p.a_bottom);
            bx1 = lo_of(p.b_left, p.b_right);
            bx2 = hi_of(p.b_left, p.b_right);
            by1 = lo_of(p.b_top, p.b_bottom);
            by2 = hi_of(p.b_top, p.b_bottom);
            pairs++;
            if (ax2 <= bx1 || bx2 <= ax1 || ay2 <= by1 || by2 <= ay1 ||
                ax1 == ax2 || ay1 == ay2 || bx1 == bx2 || by1 == by2) begin
                r = '0;
                r.status = rd_pkg::ST_NO_OVERLAP;
                batch = {batch, r};
                no_overlap_cnt++;
            end else begin
                cx1 = (ax1 > bx1) ? ax1 : bx1;
                cx2 = (ax2 < bx2) ? ax2 : bx2;
                if (ax1 < bx1) begin
                    batch = {batch, make_piece(rd_pkg::KIND_LEFT, ax1, ay1,
                                               bx1 - ax1, ay2 - ay1)};
                end
                if (ax2 > bx2) begin
                    batch = {batch, make_piece(rd_pkg::KIND_RIGHT, bx2, ay1,
                                               ax2 - bx2, ay2 - ay1)};
                end
                if (ay1 < by1) begin
                    batch = {batch, make_piece(rd_pkg::KIND_TOP, cx1, ay1,
                                               cx2 - cx1, by1 - ay1)};
                end
                if (ay2 > by2) begin
                    batch = {batch, make_piece(rd_pkg::KIND_BOTTOM, cx1, by2,
                                               cx2 - cx1, ay2 - by2)};
                end
                piece_cnt += batch.size();
                if (batch.size() == 0) begin
                    r = '0;
                    r.status = rd_pkg::ST_COVERED;
                    batch = {batch, r};
                    covered_cnt++;
                end
            end
            batch[batch.size() - 1].last = 1'b1;
            expected_q = {expected_q, batch};
        endfunction

        task check_beat(rd_pkg::t_rd_out got);
            rd_pkg::t_rd_out want;
            beats++;
            if (expected_q.size() == 0) begin
                flag_mismatch($sformatf("beat %0d with nothing pending: %p", beats, got));
                return;
            end
            want = expected_q.pop_front();
            if (got.status !== want.status) begin
                flag_mismatch($sformatf("beat %0d status %0d, want %0d",
                                        beats, got.status, want.status));
            end
            if (got.piece_left !== want.piece_left) begin
                flag_mismatch($sformatf("beat %0d piece_left %0d, want %0d",
                                        beats, got.piece_left, want.piece_left));
            end
            if (got.piece_top !== want.piece_top) begin
                flag_mismatch($sformatf("beat %0d piece_top %0d, want %0d",
                                        beats, got.piece_top, want.piece_top));
            end
            if (got.piece_width !== want.piece_width) begin
                flag_mismatch($sformatf("beat %0d piece_width %0d, want %0d",
                                        beats, got.piece_width, want.piece_width));
            end
            if (got.piece_height !== want.piece_height) begin
                flag_mismatch($sformatf("beat %0d piece_height %0d, want %0d",
                                        beats, got.piece_height, want.piece_height));
            end
            if (got.piece_kind !== want.piece_kind) begin
                flag_mismatch($sformatf("beat %0d piece_kind %0d, want %0d",
                                        beats, got.piece_kind, want.piece_kind));
            end
            if (got.last !== want.last) begin
                flag_mismatch($sformatf("beat %0d last %0b, want %0b",
                                        beats, got.last, want.last));
            end
        endtask
    endclass

    logic            clk       = 1'b0;
    logic            rst_n     = 1'b0;
    logic            in_valid  = 1'b0;
    rd_pkg::t_rd_in  in_beat   = '0;
    logic            out_stall = 1'b0;
    logic            quiet     = 1'b0;
    logic            in_stall;
    logic            out_valid;
    rd_pkg::t_rd_out out_beat;

    rect_scoreboard sb = new();

    always #5 clk = ~clk;

    rectangle_difference u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_beat   (in_beat),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_beat  (out_beat)
    );

    function automatic rd_pkg::t_rd_in make_pair(int al, int at, int ar, int ab,
                                                 int bl, int bt, int br, int bb);
        rd_pkg::t_rd_in p;
        p.a_left   = rd_pkg::t_coord'(al);
        p.a_top    = rd_pkg::t_coord'(at);
        p.a_right  = rd_pkg::t_coord'(ar);
        p.a_bottom = rd_pkg::t_coord'(ab);
        p.b_left   = rd_pkg::t_coord'(bl);
        p.b_top    = rd_pkg::t_coord'(bt);
        p.b_right  = rd_pkg::t_coord'(br);
        p.b_bottom = rd_pkg::t_coord'(bb);
        return p;
    endfunction

    // mostly clustered corners so the boxes overlap; some extremes and raw noise
    function automatic rd_pkg::t_rd_in random_pair();
        int mode;
        int bx;
        int by;
        int c[8];
        mode = $urandom_range(0, 19);
        bx   = $urandom_range(0, 65455) - 32764;
        by   = $urandom_range(0, 65455) - 32764;
        for (int k = 0; k < 8; k++) begin
            if (mode < 12) begin
                c[k] = ((k % 2) == 0 ? bx : by) + $urandom_range(0, 40);
            end else if (mode < 15) begin
                c[k] = CORNER_VALS[$urandom_range(0, 7)];
            end else if (mode < 17) begin
                c[k] = int'(rd_pkg::t_coord'($urandom));
            end else if (k < 4) begin
                c[k] = ((k % 2) == 0 ? bx : by) + $urandom_range(0, 40);
            end else begin
                c[k] = c[k - 4] + $urandom_range(0, 6) - 3;
            end
        end
        return make_pair(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7]);
    endfunction

    task automatic send_pair(input rd_pkg::t_rd_in p);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_beat  <= p;
        do @(posedge clk); while (in_stall !== 1'b0);
        sb.note_pair(p);
    endtask

    initial begin : result_sink
        int hold;
        while (rst_n !== 1'b1) @(posedge clk);
        forever begin
            hold = quiet ? 0 : $urandom_range(0, 14);
            if (hold > 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
                out_stall <= 1'b0;
            end
            do @(posedge clk); while (out_valid !== 1'b1);
            sb.check_beat(out_beat);
        end
    end

    initial begin : stimulus
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // touching edges, empty boxes, full cover
        send_pair(make_pair(0, 0, 10, 10, 10, 0, 20, 10));
        send_pair(make_pair(0, 0, 10, 10, -5, 0, 0, 10));
        send_pair(make_pair(0, 0, 10, 10, 0, 10, 10, 20));
        send_pair(make_pair(0, 0, 10, 10, 0, -10, 10, 0));
        send_pair(make_pair(5, 0, 5, 10, 0, 0, 10, 10));
        send_pair(make_pair(0, 5, 10, 5, 0, 0, 10, 10));
        send_pair(make_pair(0, 0, 10, 10, 3, 0, 3, 10));
        send_pair(make_pair(0, 0, 10, 10, 0, 4, 10, 4));
        send_pair(make_pair(0, 0, 10, 10, 0, 0, 10, 10));
        send_pair(make_pair(2, 2, 8, 8, -100, -100, 100, 100));
        // all four piece kinds, then one kind at a time, then left and bottom together
        send_pair(make_pair(0, 0, 10, 10, 3, 3, 6, 6));
        send_pair(make_pair(0, 0, 10, 10, 3, -5, 20, 20));
        send_pair(make_pair(0, 0, 10, 10, -5, -5, 6, 20));
        send_pair(make_pair(0, 0, 10, 10, -5, 4, 20, 20));
        send_pair(make_pair(0, 0, 10, 10, -5, -5, 20, 7));
        send_pair(make_pair(0, 0, 10, 10, 5, -5, 15, 5));
        // reversed corners
        send_pair(make_pair(10, 10, 0, 0, 6, 6, 3, 3));
        send_pair(make_pair(10, 0, 0, 10, 3, 6, 6, 3));
        // coordinate extremes and the widest pieces
        send_pair(make_pair(-32768, -32768, 32767, 32767, 0, 0, 1, 1));
        send_pair(make_pair(-32768, -32768, 32767, 32767, -32768, -1, 32767, 0));
        send_pair(make_pair(-32768, -32768, 32767, 32767, 32766, -32768, 32767, 32767));
        send_pair(make_pair(32767, 32767, -32768, -32768, -32768, -32768, 32767, 32767));
        send_pair(make_pair(-32768, 0, -32768, 0, -32768, 0, -32768, 0));
        send_pair(make_pair(32767, -32768, -32768, 32767, -32767, 32766, 32766, -32767));

        for (int k = 0; k < 360; k++) begin
            quiet = ((k / 60) % 3 == 2);
            send_pair(random_pair());
        end
        quiet = 1'b0;
        in_valid <= 1'b0;

        while (sb.expected_q.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Sent %0d rectangle pairs, checked %0d result beats.", sb.pairs, sb.beats);
        $display("Expected %0d no-overlap, %0d covered, %0d pieces; %0d mismatches.",
                 sb.no_overlap_cnt, sb.covered_cnt, sb.piece_cnt, sb.errors);
        if (sb.errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin : watchdog
        #3_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
